// ----- src/bffc_pkg.sv -----
// Package for the binned flat-field correction core.
// Holds shared constants and register indexes; no dependencies.
`default_nettype none
package bffc_pkg;
  localparam int unsigned FlatWidthDef  = 2048;
  localparam int unsigned FlatHeightDef = 2048;
  localparam int unsigned MaxBinDef     = 8;
  localparam int unsigned EntryW        = 19;
  localparam logic [17:0] FlatValMax    = 18'h3FFFF;
  localparam logic [1:0]  RegWinX       = 2'd0;
  localparam logic [1:0]  RegWinY       = 2'd1;
  localparam logic [1:0]  RegBinX       = 2'd2;
  localparam logic [1:0]  RegBinY       = 2'd3;
endpackage
`default_nettype wire

// ----- src/bffc_ram.sv -----
// Generic single-port synchronous RAM with a registered read.
// No dependencies.
`default_nettype none
module bffc_ram #(
  parameter int unsigned Width = 19,
  parameter int unsigned Depth = 1024
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] addr_i,
  input  wire logic [Width-1:0]         wdata_i,
  output logic      [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem [Depth];
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[addr_i] <= wdata_i;
    end
    rdata_o <= mem[addr_i];
  end
endmodule
`default_nettype wire

// ----- src/bffc_div.sv -----
// Restoring divider, one quotient bit per cycle, 64 by 32 bits.
// No dependencies.
`default_nettype none
module bffc_div (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start_i,
  input  wire logic [63:0] num_i,
  input  wire logic [31:0] den_i,
  output logic             done_o,
  output logic [63:0]      quot_o
);
  logic [63:0] quot_q, quot_d;
  logic [32:0] rem_q, rem_d;
  logic [31:0] den_q;
  logic [6:0]  cnt_q, cnt_d;
  logic        run_q, run_d, done_q, done_d;
  logic [32:0] trial;

  assign trial = {rem_q[31:0], quot_q[63]} - {1'b0, den_q};

  always_comb begin
    quot_d = quot_q;
    rem_d  = rem_q;
    cnt_d  = cnt_q;
    run_d  = run_q;
    done_d = 1'b0;
    if (start_i) begin
      quot_d = num_i;
      rem_d  = '0;
      cnt_d  = 7'd64;
      run_d  = 1'b1;
    end else if (run_q) begin
      if (!trial[32]) begin
        rem_d  = trial;
        quot_d = {quot_q[62:0], 1'b1};
      end else begin
        rem_d  = {rem_q[31:0], quot_q[63]};
        quot_d = {quot_q[62:0], 1'b0};
      end
      cnt_d = cnt_q - 7'd1;
      if (cnt_q == 7'd1) begin
        run_d  = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      run_q  <= run_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quot_q <= quot_d;
    rem_q  <= rem_d;
    if (start_i) begin
      den_q <= den_i;
    end
  end

  assign done_o = done_q;
  assign quot_o = quot_q;
endmodule
`default_nettype wire

// ----- src/binned_flat_field_correction_core.sv -----
// Top level of the binned flat-field correction core.
// Depends on bffc_pkg, bffc_ram and bffc_div.
//
// Requests enter on start_i while busy_o is low. A load request (kind 0)
// writes one flat entry at the accepting edge if its position lies inside
// the flat, gives no result and leaves busy_o low, so loads can follow one
// per cycle. A pixel request (kind 1) reads its bin_x by bin_y flat entries
// from the store, one per cycle, then divides with a bit-serial divider.
// The result is shown with valid_o. A null raw pixel skips the store and
// the divider; an out-of-range or null flat entry or a zero sum skips the
// divider. busy_o falls in the result cycle, so the next request can be
// accepted at its end. The receiver cannot stall; each result is shown
// once. Reset sets the offsets to 0 and the bins to 1; the store itself is
// not cleared. Configuration writes use cfg_valid_i/cfg_ready_o and are
// always taken.
`default_nettype none
module binned_flat_field_correction_core #(
  parameter int unsigned FlatWidth  = bffc_pkg::FlatWidthDef,
  parameter int unsigned FlatHeight = bffc_pkg::FlatHeightDef,
  parameter int unsigned MaxBin     = bffc_pkg::MaxBinDef
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start_i,
  output logic             busy_o,
  input  wire logic        kind_i,
  input  wire logic [10:0] pos_x_i,
  input  wire logic [10:0] pos_y_i,
  input  wire logic [23:0] sample_i,
  input  wire logic        sample_is_null_i,
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [1:0]  cfg_index_i,
  input  wire logic [31:0] cfg_data_i,
  output logic             valid_o,
  output logic [31:0]      corrected_o,
  output logic             result_null_o,
  output logic             flat_out_of_range_o
);
  localparam int unsigned XW = $clog2(FlatWidth);
  localparam int unsigned YW = $clog2(FlatHeight);
  localparam int unsigned AW = $clog2(FlatWidth * FlatHeight);
  localparam int unsigned CW = 17;
  localparam logic [4:0] MaxBinV = 5'(MaxBin);
  localparam logic [2:0] SIdle = 3'd0, SRead = 3'd1, SLast = 3'd2,
                         SDiv = 3'd3, SOut = 3'd4;

  logic [2:0]  st_q, st_d;
  logic [10:0] wx_q, wy_q;
  logic [3:0]  bx_q, by_q;
  logic [4:0]  cbx, cby, bxe_q, bye_q, i_q, j_q;
  logic [CW-1:0] fx_q, fy_q, basex_q;
  logic [23:0] raw_q;
  logic [31:0] sum_q;
  logic        anynull_q, oor_q, rdv_q;
  logic        we, ram_rd;
  logic [AW-1:0] addr;
  logic [bffc_pkg::EntryW-1:0] wdata, rdata;
  logic [17:0] lval;
  logic        div_start, div_done;
  logic [63:0] div_num, quot;
  logic [31:0] res_q;
  logic        rnull_q, roor_q, vld_q;
  logic [31:0] sum_n;
  logic        null_n;
  logic [CW-1:0] fx0, fy0;

  assign cbx = (bx_q == 4'd0) ? 5'd1 : ({1'b0, bx_q} > MaxBinV) ? MaxBinV : {1'b0, bx_q};
  assign cby = (by_q == 4'd0) ? 5'd1 : ({1'b0, by_q} > MaxBinV) ? MaxBinV : {1'b0, by_q};
  assign fx0 = CW'(wx_q) + CW'(pos_x_i) * CW'(cbx);
  assign fy0 = CW'(wy_q) + CW'(pos_y_i) * CW'(cby);

  assign busy_o = (st_q != SIdle);
  assign cfg_ready_o = 1'b1;
  assign lval = (sample_i > 24'(bffc_pkg::FlatValMax)) ? bffc_pkg::FlatValMax : sample_i[17:0];
  assign wdata = {sample_is_null_i, lval};
  assign we = start_i && !busy_o && !kind_i &&
              (32'(pos_x_i) < FlatWidth) && (32'(pos_y_i) < FlatHeight);
  assign ram_rd = (st_q == SRead) && (fx_q < CW'(FlatWidth)) && (fy_q < CW'(FlatHeight));
  assign addr = we ? AW'(pos_y_i) * AW'(FlatWidth) + AW'(pos_x_i)
                   : AW'(fy_q[YW-1:0]) * AW'(FlatWidth) + AW'(fx_q[XW-1:0]);

  bffc_ram #(.Width(bffc_pkg::EntryW), .Depth(FlatWidth * FlatHeight)) u_ram (
    .clk_i, .we_i(we), .addr_i(addr), .wdata_i(wdata), .rdata_o(rdata)
  );

  assign sum_n  = sum_q + ((rdv_q && !rdata[18]) ? 32'(rdata[17:0]) : 32'd0);
  assign null_n = anynull_q | (rdv_q & rdata[18]);
  assign div_num = (64'(raw_q) * 64'(9'(bxe_q) * 9'(bye_q))) << 24;
  assign div_start = (st_q == SLast) && !oor_q && !null_n && (sum_n != 32'd0);

  bffc_div u_div (
    .clk_i, .rst_ni, .start_i(div_start), .num_i(div_num), .den_i(sum_n),
    .done_o(div_done), .quot_o(quot)
  );

  always_comb begin
    st_d = st_q;
    case (st_q)
      SIdle: if (start_i && kind_i) st_d = sample_is_null_i ? SOut : SRead;
      SRead: if (i_q == bxe_q - 5'd1 && j_q == bye_q - 5'd1) st_d = SLast;
      SLast: st_d = div_start ? SDiv : SOut;
      SDiv:  if (div_done) st_d = SOut;
      SOut:  st_d = SIdle;
      default: st_d = SIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= SIdle;
      wx_q <= '0;
      wy_q <= '0;
      bx_q <= 4'd1;
      by_q <= 4'd1;
      vld_q <= 1'b0;
      rdv_q <= 1'b0;
    end else begin
      st_q  <= st_d;
      vld_q <= (st_q == SOut);
      rdv_q <= ram_rd;
      if (cfg_valid_i) begin
        case (cfg_index_i)
          bffc_pkg::RegWinX: wx_q <= cfg_data_i[10:0];
          bffc_pkg::RegWinY: wy_q <= cfg_data_i[10:0];
          bffc_pkg::RegBinX: bx_q <= cfg_data_i[3:0];
          bffc_pkg::RegBinY: by_q <= cfg_data_i[3:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    case (st_q)
      SIdle: begin
        raw_q <= sample_i;
        bxe_q <= cbx;
        bye_q <= cby;
        i_q <= '0;
        j_q <= '0;
        fx_q <= fx0;
        fy_q <= fy0;
        basex_q <= fx0;
        sum_q <= '0;
        anynull_q <= 1'b0;
        oor_q <= 1'b0;
        res_q <= '0;
        rnull_q <= 1'b1;
        roor_q <= 1'b0;
      end
      SRead: begin
        sum_q <= sum_n;
        anynull_q <= null_n;
        if (!ram_rd) oor_q <= 1'b1;
        if (i_q == bxe_q - 5'd1) begin
          i_q <= '0;
          fx_q <= basex_q;
          j_q <= j_q + 5'd1;
          fy_q <= fy_q + CW'(1);
        end else begin
          i_q <= i_q + 5'd1;
          fx_q <= fx_q + CW'(1);
        end
      end
      SLast: begin
        sum_q <= sum_n;
        anynull_q <= null_n;
        roor_q <= oor_q;
      end
      SDiv: if (div_done) begin
        res_q <= (quot[63:32] != 32'd0) ? 32'hFFFFFFFF : quot[31:0];
        rnull_q <= 1'b0;
      end
      default: ;
    endcase
  end

  assign valid_o = vld_q;
  assign corrected_o = res_q;
  assign result_null_o = rnull_q;
  assign flat_out_of_range_o = roor_q;

  a_null_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && result_null_o |-> corrected_o == 32'd0) else $error("null result nonzero");
  a_oor_null: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && flat_out_of_range_o |-> result_null_o) else $error("oor not null");
  a_no_write_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_o |-> !we) else $error("write while busy");
endmodule
`default_nettype wire
